// ===== hdl/urc_pkg.sv =====
package urc_pkg;

    // Widths of the configuration registers and of the working counters.
    localparam int PULSE_W  = 10;
    localparam int TICK_W   = 16;
    localparam int SCALE_W  = 24;
    localparam int PERIOD_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = TICK_W + SCALE_W;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    // Reset values of the configuration registers.
    localparam logic [PULSE_W-1:0]  PULSE_RST   = 10'd10;
    localparam logic [TICK_W-1:0]   TIMEOUT_RST = 16'd30000;
    localparam logic [TICK_W-1:0]   DELAY_RST   = 16'd10000;
    localparam logic [SCALE_W-1:0]  SCALE_RST   = 24'd143166;
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 24'd100000;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Measurement phases, encoded as reported on the phase field.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PULSE   = 3'd1,
        PH_WAIT    = 3'd2,
        PH_TIMING  = 3'd3,
        PH_DELAY   = 3'd4,
        PH_PENDING = 3'd5
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_TICKS   = 3'd0,
        CFG_TIMEOUT_TICKS = 3'd1,
        CFG_DELAY_TICKS   = 3'd2,
        CFG_RANGE_SCALE   = 3'd3,
        CFG_READ_MODE     = 3'd4,
        CFG_PERIOD_TICKS  = 3'd5
    } t_cfg_idx;

    // Saturating increment of a tick counter.
    function automatic logic [TICK_W-1:0] inc_sat(input logic [TICK_W-1:0] v);
        inc_sat = (v == TICK_MAX) ? v : v + TICK_W'(1);
    endfunction

endpackage

// ===== hdl/ultrasonic_ranging_controller_core.sv =====
// Ultrasonic trigger/echo ranging controller.
//
// The slave stream carries one item per microsecond tick: tdata[0] is the
// echo pin level and tdata[1] a start request. For every accepted item the
// master stream returns one result: the trigger pin level, a done flag on
// the tick a reading completes, the last distance as a Q0.16 fraction of
// full range, the no-echo flag of the last reading and the current phase.
// The configuration channel writes one register per transfer; it is always
// ready and is meant to be written while no tick is in flight.
//
// An item is registered in the input register on acceptance and its result is
// registered in the result register once that register is free or draining;
// o_m_tvalid and o_m_tdata are driven from the result register.
// Throughput is one item per cycle while the receiver does not stall: the input
// register and the result register form a two-stage pipeline, and the only deep
// path is one 16 x 24 multiply in the reading-completion logic.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; s_tready then drops until the result drains.
// Reset (synchronous, active low) returns the configuration, sequencer and valid
// registers to their defaults and the controller to idle with no reading recorded.
module ultrasonic_ranging_controller_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave stream: [0] echo_level, [1] start_request, [7:2] zero.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [urc_pkg::S_DATA_W-1:0]       i_s_tdata,
    // Master stream: [0] trigger_level, [1] reading_done, [17:2] distance_frac,
    // [18] no_echo, [21:19] phase, [23:22] zero.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [urc_pkg::M_DATA_W-1:0]       o_m_tdata,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [urc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [urc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [urc_pkg::PULSE_W-1:0]  r_pulse_ticks;
    logic [urc_pkg::TICK_W-1:0]   r_timeout_ticks;
    logic [urc_pkg::TICK_W-1:0]   r_delay_ticks;
    logic [urc_pkg::SCALE_W-1:0]  r_range_scale;
    logic                         r_read_mode;
    logic [urc_pkg::PERIOD_W-1:0] r_period_ticks;

    // Controller state.
    urc_pkg::t_phase              r_phase, n_phase;
    logic [urc_pkg::TICK_W-1:0]   r_phase_cnt, n_phase_cnt;
    logic [urc_pkg::TICK_W-1:0]   r_timeout_cnt, n_timeout_cnt;
    logic [urc_pkg::TICK_W-1:0]   r_echo_ticks, n_echo_ticks;
    logic                         r_echo_prev;
    logic [urc_pkg::TICK_W-1:0]   r_last_dist, n_last_dist;
    logic                         r_last_no_echo, n_last_no_echo;
    logic [urc_pkg::PERIOD_W-1:0] r_period_cnt, n_period_cnt;

    // Pipeline registers.
    logic                         r_in_valid;
    logic                         r_in_echo;
    logic                         r_in_req;
    logic                         r_out_valid;
    logic [urc_pkg::M_DATA_W-1:0] r_out_data;
    logic                         n_done;

    logic                         w_advance;
    logic                         w_step;
    logic                         w_rise;
    logic                         w_fall;
    logic                         w_req;
    logic [urc_pkg::TICK_W:0]     w_cont_limit;
    logic [urc_pkg::PROD_W-1:0]   w_prod;

    // The input stage moves on whenever the result register is free or draining.
    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_advance;
    assign o_s_tready = !r_in_valid || w_advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_cfg_ready = 1'b1;

    // Echo edges against the level seen on the previous tick.
    assign w_rise = r_in_echo && !r_echo_prev;
    assign w_fall = !r_in_echo && r_echo_prev;

    // Back-to-back continuous reading when the period does not exceed the timeout plus the pulse length.
    assign w_cont_limit = {1'b0, r_timeout_ticks}
                        + (urc_pkg::TICK_W + 1)'(r_pulse_ticks);

    // Distance product uses the echo count after this tick's increment.
    assign w_prod = urc_pkg::PROD_W'(urc_pkg::inc_sat(r_echo_ticks))
                  * urc_pkg::PROD_W'(r_range_scale);

    // Next state of the measurement sequencer for the item in the input register.
    always_comb begin
        n_phase        = r_phase;
        n_phase_cnt    = r_phase_cnt;
        n_timeout_cnt  = r_timeout_cnt;
        n_echo_ticks   = r_echo_ticks;
        n_last_dist    = r_last_dist;
        n_last_no_echo = r_last_no_echo;
        n_period_cnt   = r_period_cnt;
        n_done         = 1'b0;
        w_req          = r_in_req;

        // Request generation in continuous mode.
        if (r_read_mode) begin
            if (r_period_ticks <= urc_pkg::PERIOD_W'(w_cont_limit)) begin
                w_req = 1'b1;
            end else begin
                n_period_cnt = r_period_cnt + urc_pkg::PERIOD_W'(1);
                if (n_period_cnt >= r_period_ticks) begin
                    w_req        = 1'b1;
                    n_period_cnt = '0;
                end
            end
        end else begin
            n_period_cnt = '0;
        end

        case (r_phase)
            urc_pkg::PH_IDLE: begin
                if (w_req) begin
                    n_phase     = urc_pkg::PH_PULSE;
                    n_phase_cnt = urc_pkg::TICK_W'(1);
                end
            end
            urc_pkg::PH_PULSE: begin
                if (r_phase_cnt >= urc_pkg::TICK_W'(r_pulse_ticks)) begin
                    n_phase       = urc_pkg::PH_WAIT;
                    n_timeout_cnt = '0;
                end else begin
                    n_phase_cnt = urc_pkg::inc_sat(r_phase_cnt);
                end
            end
            urc_pkg::PH_WAIT, urc_pkg::PH_TIMING: begin
                n_timeout_cnt = urc_pkg::inc_sat(r_timeout_cnt);
                if (r_phase == urc_pkg::PH_WAIT) begin
                    if (w_rise) begin
                        n_phase      = urc_pkg::PH_TIMING;
                        n_echo_ticks = '0;
                    end
                end else begin
                    n_echo_ticks = urc_pkg::inc_sat(r_echo_ticks);
                    if (w_fall) begin
                        n_last_dist    = (|w_prod[urc_pkg::PROD_W-1:32])
                                         ? urc_pkg::TICK_MAX : w_prod[31:16];
                        n_last_no_echo = 1'b0;
                        n_done         = 1'b1;
                    end
                end
                // A falling edge wins over a timeout on the same tick.
                if (!n_done && n_timeout_cnt >= r_timeout_ticks) begin
                    n_last_dist    = urc_pkg::TICK_MAX;
                    n_last_no_echo = 1'b1;
                    n_done         = 1'b1;
                end
                if (n_done) begin
                    n_phase     = w_req ? urc_pkg::PH_PENDING : urc_pkg::PH_DELAY;
                    n_phase_cnt = '0;
                end
            end
            urc_pkg::PH_DELAY, urc_pkg::PH_PENDING: begin
                if (w_req) begin
                    n_phase = urc_pkg::PH_PENDING;
                end
                n_phase_cnt = urc_pkg::inc_sat(r_phase_cnt);
                if (n_phase_cnt >= r_delay_ticks) begin
                    if (n_phase == urc_pkg::PH_PENDING) begin
                        n_phase     = urc_pkg::PH_PULSE;
                        n_phase_cnt = urc_pkg::TICK_W'(1);
                    end else begin
                        n_phase = urc_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = urc_pkg::PH_IDLE;
            end
        endcase
    end

    // Input register and result register valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input payload capture on each transfer.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_echo <= i_s_tdata[0];
            r_in_req  <= i_s_tdata[1];
        end
    end

    // Result payload, packed from the state after this tick.
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= {2'b00, n_phase, n_last_no_echo, n_last_dist, n_done,
                           (n_phase == urc_pkg::PH_PULSE)};
        end
    end

    // Sequencer state; configuration writes to the mode or period clear the period count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= urc_pkg::PH_IDLE;
            r_phase_cnt    <= '0;
            r_timeout_cnt  <= '0;
            r_echo_ticks   <= '0;
            r_echo_prev    <= 1'b0;
            r_last_dist    <= '0;
            r_last_no_echo <= 1'b0;
            r_period_cnt   <= '0;
        end else begin
            if (w_step) begin
                r_phase        <= n_phase;
                r_phase_cnt    <= n_phase_cnt;
                r_timeout_cnt  <= n_timeout_cnt;
                r_echo_ticks   <= n_echo_ticks;
                r_echo_prev    <= r_in_echo;
                r_last_dist    <= n_last_dist;
                r_last_no_echo <= n_last_no_echo;
            end
            if (i_cfg_valid && (i_cfg_index == urc_pkg::CFG_READ_MODE ||
                                i_cfg_index == urc_pkg::CFG_PERIOD_TICKS)) begin
                r_period_cnt <= '0;
            end else if (w_step) begin
                r_period_cnt <= n_period_cnt;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks   <= urc_pkg::PULSE_RST;
            r_timeout_ticks <= urc_pkg::TIMEOUT_RST;
            r_delay_ticks   <= urc_pkg::DELAY_RST;
            r_range_scale   <= urc_pkg::SCALE_RST;
            r_read_mode     <= 1'b0;
            r_period_ticks  <= urc_pkg::PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                urc_pkg::CFG_PULSE_TICKS:   r_pulse_ticks   <= i_cfg_data[urc_pkg::PULSE_W-1:0];
                urc_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[urc_pkg::TICK_W-1:0];
                urc_pkg::CFG_DELAY_TICKS:   r_delay_ticks   <= i_cfg_data[urc_pkg::TICK_W-1:0];
                urc_pkg::CFG_RANGE_SCALE:   r_range_scale   <= i_cfg_data[urc_pkg::SCALE_W-1:0];
                urc_pkg::CFG_READ_MODE:     r_read_mode     <= i_cfg_data[0];
                urc_pkg::CFG_PERIOD_TICKS:  r_period_ticks  <= i_cfg_data[urc_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // A held item is never dropped while the result register is stalled.
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |=> r_in_valid)
        else $error("input item lost during output stall");

    // A completed reading is always followed by the guard delay.
    a_done_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[1]) |->
        (r_out_data[21:19] == urc_pkg::PH_DELAY ||
         r_out_data[21:19] == urc_pkg::PH_PENDING))
        else $error("reading completed outside the delay phase");

    // A timed-out reading reports full scale.
    a_no_echo_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[18]) |-> (r_out_data[17:2] == urc_pkg::TICK_MAX))
        else $error("no-echo reading without full-scale distance");

    // The trigger is high exactly in the pulse phase.
    a_trig_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[0] == (r_out_data[21:19] == urc_pkg::PH_PULSE)))
        else $error("trigger level disagrees with phase");

endmodule

// ===== tb/ultrasonic_ranging_controller_core_test.sv =====
module ultrasonic_ranging_controller_core_test;

    localparam int WATCHDOG_LIMIT = 2000;

    // One microsecond tick as offered on the slave stream.
    typedef struct packed {
        logic echo;
        logic start;
    } t_tick_item;

    // One result as returned on the master stream.
    typedef struct {
        logic                       trigger;
        logic                       done;
        logic [urc_pkg::TICK_W-1:0] distance;
        logic                       no_echo;
        urc_pkg::t_phase            phase;
    } t_reading;

    // Receiver stall patterns.
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_MOSTLY
    } t_stall;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [urc_pkg::S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b1;
    logic [urc_pkg::M_DATA_W-1:0]   o_m_tdata;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [urc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [urc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Register copies used by the predictor.
    logic [urc_pkg::PULSE_W-1:0]  cfg_pulse;
    logic [urc_pkg::TICK_W-1:0]   cfg_timeout;
    logic [urc_pkg::TICK_W-1:0]   cfg_delay;
    logic [urc_pkg::SCALE_W-1:0]  cfg_scale;
    logic                         cfg_mode;
    logic [urc_pkg::PERIOD_W-1:0] cfg_period;

    // Controller state as the predictor tracks it.
    urc_pkg::t_phase              ph;
    logic [urc_pkg::TICK_W-1:0]   ph_cnt;
    logic [urc_pkg::TICK_W-1:0]   tmo_cnt;
    logic [urc_pkg::TICK_W-1:0]   echo_cnt;
    logic                         echo_last;
    logic [urc_pkg::TICK_W-1:0]   dist_reg;
    logic                         noecho_reg;
    logic [urc_pkg::PERIOD_W-1:0] per_cnt;

    t_tick_item pending_ticks[$];
    t_reading   expected_readings[$];

    int     n_queued     = 0;
    int     n_ticks      = 0;
    int     n_results    = 0;
    int     n_readings   = 0;
    int     n_no_echo    = 0;
    int     n_writes     = 0;
    int     n_settings   = 0;
    int     n_mismatch   = 0;
    int     idle_cycles  = 0;
    bit     s_xfer       = 1'b0;
    int     burst_left   = 1;
    int     gap_left     = 0;
    int     stall_span   = 0;
    t_stall stall_mode   = RX_STEADY;

    ultrasonic_ranging_controller_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Counter increment that sticks at the top value.
    function automatic logic [urc_pkg::TICK_W-1:0] bump(input logic [urc_pkg::TICK_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Registers and controller state after reset.
    function automatic void reset_ranging();
        cfg_pulse   = urc_pkg::PULSE_RST;
        cfg_timeout = urc_pkg::TIMEOUT_RST;
        cfg_delay   = urc_pkg::DELAY_RST;
        cfg_scale   = urc_pkg::SCALE_RST;
        cfg_mode    = 1'b0;
        cfg_period  = urc_pkg::PERIOD_RST;
        ph          = urc_pkg::PH_IDLE;
        ph_cnt      = '0;
        tmo_cnt     = '0;
        echo_cnt    = '0;
        echo_last   = 1'b0;
        dist_reg    = '0;
        noecho_reg  = 1'b0;
        per_cnt     = '0;
    endfunction

    // A register write as the controller sees it.
    function automatic void apply_reg(input urc_pkg::t_cfg_idx idx,
                                      input logic [urc_pkg::CFG_DATA_W-1:0] v);
        case (idx)
            urc_pkg::CFG_PULSE_TICKS:   cfg_pulse   = v[urc_pkg::PULSE_W-1:0];
            urc_pkg::CFG_TIMEOUT_TICKS: cfg_timeout = v[urc_pkg::TICK_W-1:0];
            urc_pkg::CFG_DELAY_TICKS:   cfg_delay   = v[urc_pkg::TICK_W-1:0];
            urc_pkg::CFG_RANGE_SCALE:   cfg_scale   = v[urc_pkg::SCALE_W-1:0];
            urc_pkg::CFG_READ_MODE: begin
                cfg_mode = v[0];
                per_cnt  = '0;
            end
            urc_pkg::CFG_PERIOD_TICKS: begin
                cfg_period = v[urc_pkg::PERIOD_W-1:0];
                per_cnt    = '0;
            end
            default: ;
        endcase
    endfunction

    // Advance the controller by one tick and return the result it reports.
    function automatic t_reading advance_ranging(input logic echo, input logic start);
        t_reading                   r;
        logic                       req;
        logic                       done;
        logic                       rise;
        logic                       fall;
        logic [urc_pkg::PROD_W-1:0] prod;
        req  = start;
        done = 1'b0;
        rise = echo && !echo_last;
        fall = !echo && echo_last;

        // Continuous mode raises its own requests.
        if (cfg_mode) begin
            if (32'(cfg_period) <= 32'(cfg_timeout) + 32'(cfg_pulse)) begin
                req = 1'b1;
            end else begin
                per_cnt = per_cnt + 1'b1;
                if (per_cnt >= cfg_period) begin
                    req     = 1'b1;
                    per_cnt = '0;
                end
            end
        end else begin
            per_cnt = '0;
        end

        case (ph)
            urc_pkg::PH_IDLE: begin
                if (req) begin
                    ph     = urc_pkg::PH_PULSE;
                    ph_cnt = urc_pkg::TICK_W'(1);
                end
            end
            urc_pkg::PH_PULSE: begin
                if (ph_cnt >= urc_pkg::TICK_W'(cfg_pulse)) begin
                    ph      = urc_pkg::PH_WAIT;
                    tmo_cnt = '0;
                end else begin
                    ph_cnt = bump(ph_cnt);
                end
            end
            urc_pkg::PH_WAIT, urc_pkg::PH_TIMING: begin
                tmo_cnt = bump(tmo_cnt);
                if (ph == urc_pkg::PH_WAIT) begin
                    if (rise) begin
                        ph       = urc_pkg::PH_TIMING;
                        echo_cnt = '0;
                    end
                end else begin
                    echo_cnt = bump(echo_cnt);
                    if (fall) begin
                        prod       = urc_pkg::PROD_W'(echo_cnt) * urc_pkg::PROD_W'(cfg_scale);
                        dist_reg   = (prod[urc_pkg::PROD_W-1:32] != '0) ? '1 : prod[31:16];
                        noecho_reg = 1'b0;
                        done       = 1'b1;
                    end
                end
                // A falling edge on the same tick beats the timeout.
                if (!done && tmo_cnt >= cfg_timeout) begin
                    dist_reg   = '1;
                    noecho_reg = 1'b1;
                    done       = 1'b1;
                end
                if (done) begin
                    ph     = req ? urc_pkg::PH_PENDING : urc_pkg::PH_DELAY;
                    ph_cnt = '0;
                end
            end
            urc_pkg::PH_DELAY, urc_pkg::PH_PENDING: begin
                if (req) ph = urc_pkg::PH_PENDING;
                ph_cnt = bump(ph_cnt);
                if (ph_cnt >= cfg_delay) begin
                    if (ph == urc_pkg::PH_PENDING) begin
                        ph     = urc_pkg::PH_PULSE;
                        ph_cnt = urc_pkg::TICK_W'(1);
                    end else begin
                        ph = urc_pkg::PH_IDLE;
                    end
                end
            end
            default: ph = urc_pkg::PH_IDLE;
        endcase

        echo_last  = echo;
        r.trigger  = (ph == urc_pkg::PH_PULSE);
        r.done     = done;
        r.distance = dist_reg;
        r.no_echo  = noecho_reg;
        r.phase    = ph;
        return r;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic push_tick(input logic echo, input logic start);
        t_tick_item t;
        t.echo  = echo;
        t.start = start;
        pending_ticks.push_back(t);
        n_queued++;
    endtask

    // A request, a quiet lead-in, an echo of random length and a quiet tail.
    task automatic queue_measurement(input int lead_max, input int echo_max);
        push_tick(1'b0, 1'b1);
        repeat ($urandom_range(0, lead_max)) push_tick(1'b0, chance(10));
        repeat ($urandom_range(1, echo_max)) push_tick(1'b1, chance(10));
        repeat ($urandom_range(0, 6)) push_tick(1'b0, chance(30));
    endtask

    task automatic queue_noise(input int n);
        repeat (n) push_tick($urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    // Wait until every tick has been taken and every result checked.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ticks.size() != 0 || expected_readings.size() != 0 || i_s_tvalid);
        repeat (6) @(posedge i_clk);
    endtask

    // Mostly well-formed measurements with random content, the rest noise.
    task automatic run_phase(input int n_items, input int lead_max, input int echo_max);
        int first;
        first = n_queued;
        while (n_queued - first < n_items) begin
            if (chance(85)) queue_measurement(lead_max, echo_max);
            else queue_noise($urandom_range(1, 8));
        end
        wait_drained();
    endtask

    task automatic write_reg(input urc_pkg::t_cfg_idx idx,
                             input logic [urc_pkg::CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, v);
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [urc_pkg::PULSE_W-1:0] pulse,
                             input logic [urc_pkg::TICK_W-1:0] timeout,
                             input logic [urc_pkg::TICK_W-1:0] delay,
                             input logic [urc_pkg::SCALE_W-1:0] scale,
                             input logic mode,
                             input logic [urc_pkg::PERIOD_W-1:0] period);
        write_reg(urc_pkg::CFG_PULSE_TICKS, urc_pkg::CFG_DATA_W'(pulse));
        write_reg(urc_pkg::CFG_TIMEOUT_TICKS, urc_pkg::CFG_DATA_W'(timeout));
        write_reg(urc_pkg::CFG_DELAY_TICKS, urc_pkg::CFG_DATA_W'(delay));
        write_reg(urc_pkg::CFG_RANGE_SCALE, urc_pkg::CFG_DATA_W'(scale));
        write_reg(urc_pkg::CFG_READ_MODE, urc_pkg::CFG_DATA_W'(mode));
        write_reg(urc_pkg::CFG_PERIOD_TICKS, urc_pkg::CFG_DATA_W'(period));
        n_settings++;
    endtask

    // Small random setting; the period lands on, just past or away from
    // the boundary between back to back and periodic requests.
    task automatic configure_random();
        int unsigned p;
        int unsigned t;
        int unsigned span;
        p = $urandom_range(0, 4);
        t = $urandom_range(0, 30);
        case ($urandom_range(0, 2))
            0:       span = p + t;
            1:       span = p + t + 1;
            default: span = $urandom_range(0, 80);
        endcase
        configure(urc_pkg::PULSE_W'(p), urc_pkg::TICK_W'(t),
                  urc_pkg::TICK_W'($urandom_range(0, 6)), urc_pkg::SCALE_W'($urandom),
                  1'($urandom_range(0, 1)), urc_pkg::PERIOD_W'(span));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                         n_results, name, want, got);
        end
    endtask

    // Input side: record each transfer and predict its result.
    always @(posedge i_clk) begin
        t_tick_item t;
        s_xfer = i_s_tvalid && o_s_tready;
        if (s_xfer) begin
            t = pending_ticks.pop_front();
            expected_readings.push_back(advance_ranging(t.echo, t.start));
            n_ticks++;
        end
    end

    // Input side: offer ticks in bursts separated by random gaps.
    always @(negedge i_clk) begin
        if (s_xfer) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = chance(25) ? $urandom_range(50, 150) : $urandom_range(1, 12);
                gap_left   = $urandom_range(1, 5);
            end
        end
        if (i_s_tvalid && !s_xfer) begin
            // The current offer stays until it is taken.
        end else if (gap_left > 0) begin
            gap_left--;
            i_s_tvalid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= urc_pkg::S_DATA_W'({pending_ticks[0].start, pending_ticks[0].echo});
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Output side: the receiver switches between stall patterns.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = t_stall'($urandom_range(0, 3));
            stall_span = $urandom_range(16, 96);
        end
        stall_span--;
        case (stall_mode)
            RX_STEADY:      i_m_tready <= 1'b1;
            RX_COIN:        i_m_tready <= 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: i_m_tready <= (stall_span % 4 == 0);
            default:        i_m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Output side: compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_reading want;
        if (o_m_tvalid && i_m_tready) begin
            n_results++;
            if (expected_readings.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("Unexpected result %0d: tdata %h", n_results, o_m_tdata);
            end else begin
                want = expected_readings.pop_front();
                if (want.done) n_readings++;
                if (want.done && want.no_echo) n_no_echo++;
                check_field("trigger_level", want.trigger, o_m_tdata[0]);
                check_field("reading_done", want.done, o_m_tdata[1]);
                check_field("distance_frac", want.distance, o_m_tdata[17:2]);
                check_field("no_echo", want.no_echo, o_m_tdata[18]);
                check_field("phase", want.phase, o_m_tdata[21:19]);
                check_field("padding", 0, o_m_tdata[23:22]);
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired: no transfer for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        reset_ranging();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: request on idle, echo edges during the pulse, requests while
        // pulsing, request on the completion tick, falling edge while waiting,
        // timeout without echo, request during the delay, and a falling edge on
        // the tick the timeout would hit.
        configure(10'd2, 16'd6, 16'd2, 24'hFFFFFF, 1'b0, 24'd0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        repeat (2) push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        repeat (6) push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        repeat (3) push_tick(1'b0, 1'b0);
        repeat (5) push_tick(1'b1, 1'b0);
        repeat (3) push_tick(1'b0, 1'b0);
        wait_drained();

        // Single reads with no guard delay and unit scale.
        configure(10'd1, 16'd12, 16'd0, 24'h010000, 1'b0, 24'd0);
        run_phase(100, 4, 14);

        // Zero pulse and zero timeout, zero scale.
        configure(10'd0, 16'd0, 16'd1, 24'd0, 1'b0, 24'd5);
        run_phase(60, 3, 4);

        // Continuous back to back.
        configure(10'd3, 16'd20, 16'd3, 24'h0C0000, 1'b1, 24'd0);
        run_phase(100, 6, 18);

        // Continuous periodic.
        configure(10'd2, 16'd10, 16'd2, 24'h123456, 1'b1, 24'd30);
        run_phase(100, 5, 12);

        // Full-scale factor: one long echo that saturates the distance.
        configure(10'd1, 16'd400, 16'd2, 24'hFFFFFF, 1'b0, 24'd0);
        push_tick(1'b0, 1'b1);
        repeat (3) push_tick(1'b0, 1'b0);
        repeat (280) push_tick(1'b1, 1'b0);
        repeat (4) push_tick(1'b0, 1'b0);
        run_phase(40, 3, 40);

        // Small random settings.
        repeat (3) begin
            configure_random();
            run_phase(50, 6, 24);
        end

        // Largest values everywhere; the pulse outlasts the remaining ticks.
        configure(10'd1023, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF);
        run_phase(40, 3, 8);

        repeat (8) @(posedge i_clk);
        $display("Covered %0d ticks with %0d completed readings, %0d of them without echo.",
                 n_ticks, n_readings, n_no_echo);
        $display("Applied %0d register settings in %0d writes; %0d mismatches.",
                 n_settings, n_writes, n_mismatch);
        if (n_mismatch == 0 && expected_readings.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/urc_pkg.sv
hdl/ultrasonic_ranging_controller_core.sv
tb/ultrasonic_ranging_controller_core_test.sv
